FILE: rtl/core/scba_pkg.sv
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Shared widths, codes, the size-class table and the controller/datapath types.
// ----------------------------------------------------------------------------
package scba_pkg;

	// Heap geometry and field widths.
	localparam int HEAP_GRANULES = 65536;
	localparam int ADDR_W        = 16;
	localparam int SIZE_W        = 16;
	localparam int LIMIT_W       = 17;
	localparam int USABLE_W      = 13;
	localparam int STATUS_W      = 3;
	localparam int OP_W          = 2;
	localparam int NUM_CLASSES   = 16;
	localparam int CLASS_W       = 4;
	localparam int GRAN_W        = 9;
	localparam int HDR_W         = 6;

	// Block header layout: live bit, free mark, class number.
	localparam int HDR_LIVE_BIT = 5;
	localparam int HDR_FREE_BIT = 4;

	// Reset value of the heap limit register.
	localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = LIMIT_W'(HEAP_GRANULES);

	// Byte size of each size class.
	localparam logic [USABLE_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
		13'd16,   13'd32,   13'd48,   13'd64,   13'd96,   13'd128,  13'd192,  13'd256,
		13'd384,  13'd512,  13'd768,  13'd1024, 13'd1536, 13'd2048, 13'd3072, 13'd4096
	};

	// Request codes.
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2
	} op_e_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_OOM    = 3'd1,
		ST_BIG    = 3'd2,
		ST_BAD    = 3'd3,
		ST_DOUBLE = 3'd4
	} status_e_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_CLEAR = 2'd0,
		S_IDLE  = 2'd1,
		S_LOOK  = 2'd2,
		S_EXEC  = 2'd3
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic look;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} dp_status_t;

	// Result of the size-to-class mapping.
	typedef struct packed {
		logic               big;
		logic [CLASS_W-1:0] cls;
	} class_sel_t;

	// Maps a byte request (zero counts as one) to the first class that holds it.
	function automatic class_sel_t size_class(input logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] n;
		class_sel_t        r;
		n     = (sz == '0) ? SIZE_W'(1) : sz;
		r.big = 1'b1;
		r.cls = '0;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if (n <= SIZE_W'(CLASS_BYTES[i])) begin
				r.big = 1'b0;
				r.cls = CLASS_W'(i);
			end
		end
		return r;
	endfunction

	// Granules taken by a class's payload.
	function automatic logic [GRAN_W-1:0] class_granules(input logic [CLASS_W-1:0] cls);
		return GRAN_W'(CLASS_BYTES[cls] >> 4);
	endfunction

endpackage

FILE: rtl/core/scba_ctrl.sv
// ----------------------------------------------------------------------------
// Size-class block allocator controller
// Sequences the header clearing pass and the accept, look-up and execute steps
// of each item, and owns the output valid flag.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output scba_pkg::ctrl_cmd_t    cmd,
	input  scba_pkg::dp_status_t   sts
);
	import scba_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
			end
			S_EXEC: begin
				cmd.commit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set when a result is committed, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/scba_dpath.sv
// ----------------------------------------------------------------------------
// Size-class block allocator datapath
// Holds the heap limit, bump pointer, free-list heads, the header and link
// memories and the result register, and works out each item's result.
// ----------------------------------------------------------------------------
module scba_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  scba_pkg::ctrl_cmd_t              cmd,
	output scba_pkg::dp_status_t             sts,
	input  logic                             cfg_wr_en,
	input  logic [scba_pkg::LIMIT_W-1:0]     cfg_wr_data,
	input  logic [scba_pkg::OP_W-1:0]        op,
	input  logic [scba_pkg::SIZE_W-1:0]      size,
	input  logic [scba_pkg::ADDR_W-1:0]      address,
	output logic [scba_pkg::ADDR_W-1:0]      block_address,
	output logic [scba_pkg::USABLE_W-1:0]    usable_size,
	output logic [scba_pkg::STATUS_W-1:0]    status
);
	import scba_pkg::*;

	// Architectural state.
	logic [LIMIT_W-1:0]  limit_q;
	logic [LIMIT_W-1:0]  bump_q;
	logic [ADDR_W-1:0]   head_q [NUM_CLASSES];
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic [HDR_W-1:0]    hdr_mem [HEAP_GRANULES];
	logic [ADDR_W-1:0]   link_mem [HEAP_GRANULES];

	// Accepted item.
	logic [OP_W-1:0]     op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ADDR_W-1:0]   addr_q;

	// Look-up stage.
	class_sel_t          sel_c;
	logic [CLASS_W-1:0]  cls_s1;
	logic                big_s1;
	logic [ADDR_W-1:0]   top_s1;
	logic [HDR_W-1:0]    hdr_rd_s1;
	logic [ADDR_W-1:0]   link_rd_s1;

	// Execute step.
	logic [GRAN_W-1:0]   need;
	logic [LIMIT_W:0]    bump_sum;
	logic [LIMIT_W-1:0]  limit_eff;
	logic [CLASS_W-1:0]  hdr_cls;
	logic [ADDR_W-1:0]   addr_hdr;
	logic                hdr_cwe;
	logic [ADDR_W-1:0]   hdr_cwa;
	logic [HDR_W-1:0]    hdr_cwd;
	logic                link_we;
	logic                head_we;
	logic [CLASS_W-1:0]  head_wa;
	logic [ADDR_W-1:0]   head_wd;
	logic                bump_we;
	logic [ADDR_W-1:0]   res_block;
	logic [USABLE_W-1:0] res_usable;
	status_e_t           res_status;

	// Header memory write port, shared by the clearing pass and the execute step.
	logic                hdr_we;
	logic [ADDR_W-1:0]   hdr_wa;
	logic [HDR_W-1:0]    hdr_wd;

	// Result register.
	logic [ADDR_W-1:0]   out_block_q;
	logic [USABLE_W-1:0] out_usable_q;
	status_e_t           out_status_q;

	// Heap limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= HEAP_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Clearing pass counter over the header memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	assign sts.clear_last = (clr_cnt_q == '1);

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			size_q <= size;
			addr_q <= address;
		end
	end

	// Look-up: map the size to a class, fetch its list top and the memories.
	assign sel_c = size_class(size_q);

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			cls_s1     <= sel_c.cls;
			big_s1     <= sel_c.big;
			top_s1     <= head_q[sel_c.cls];
			hdr_rd_s1  <= hdr_mem[addr_q - ADDR_W'(1)];
			link_rd_s1 <= link_mem[head_q[sel_c.cls]];
		end
	end

	// Execute: work out the result and the state updates of the item.
	assign need      = class_granules(cls_s1) + GRAN_W'(1);
	assign bump_sum  = {1'b0, bump_q} + (LIMIT_W + 1)'(need);
	assign limit_eff = (limit_q > HEAP_LIMIT_RESET) ? HEAP_LIMIT_RESET : limit_q;
	assign hdr_cls   = hdr_rd_s1[CLASS_W-1:0];
	assign addr_hdr  = addr_q - ADDR_W'(1);

	always_comb begin
		res_block  = '0;
		res_usable = '0;
		res_status = ST_BAD;
		hdr_cwe    = 1'b0;
		hdr_cwa    = addr_hdr;
		hdr_cwd    = hdr_rd_s1;
		link_we    = 1'b0;
		head_we    = 1'b0;
		head_wa    = cls_s1;
		head_wd    = link_rd_s1;
		bump_we    = 1'b0;
		unique case (op_q)
			OP_ALLOC: begin
				if (big_s1) begin
					res_status = ST_BIG;
				end else if (top_s1 != '0) begin
					// Pop the class's free list and clear the free mark.
					res_block  = top_s1;
					res_usable = CLASS_BYTES[cls_s1];
					res_status = ST_OK;
					head_we    = 1'b1;
					hdr_cwe    = 1'b1;
					hdr_cwa    = top_s1 - ADDR_W'(1);
					hdr_cwd    = HDR_W'({1'b1, 1'b0, cls_s1});
				end else if (bump_sum > {1'b0, limit_eff}) begin
					res_status = ST_OOM;
				end else begin
					// Bump allocation: header granule then the payload.
					res_block  = bump_q[ADDR_W-1:0] + ADDR_W'(1);
					res_usable = CLASS_BYTES[cls_s1];
					res_status = ST_OK;
					bump_we    = 1'b1;
					hdr_cwe    = 1'b1;
					hdr_cwa    = bump_q[ADDR_W-1:0];
					hdr_cwd    = HDR_W'({1'b1, 1'b0, cls_s1});
				end
			end
			OP_FREE: begin
				if (addr_q == '0 || !hdr_rd_s1[HDR_LIVE_BIT]) begin
					res_status = ST_BAD;
				end else if (hdr_rd_s1[HDR_FREE_BIT]) begin
					res_status = ST_DOUBLE;
				end else begin
					// Mark the block free and push it on its class's list.
					res_usable = CLASS_BYTES[hdr_cls];
					res_status = ST_OK;
					hdr_cwe    = 1'b1;
					hdr_cwd    = hdr_rd_s1 | HDR_W'(1 << HDR_FREE_BIT);
					link_we    = 1'b1;
					head_we    = 1'b1;
					head_wa    = hdr_cls;
					head_wd    = addr_q;
				end
			end
			OP_QUERY: begin
				if (addr_q != '0 && hdr_rd_s1[HDR_LIVE_BIT]) begin
					res_usable = CLASS_BYTES[hdr_cls];
					res_status = ST_OK;
				end
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
	end

	// Free-list heads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= '0;
			end
		end else if (cmd.commit && head_we) begin
			head_q[head_wa] <= head_wd;
		end
	end

	// Bump pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q <= '0;
		end else if (cmd.commit && bump_we) begin
			bump_q <= bump_sum[LIMIT_W-1:0];
		end
	end

	// Header memory.
	assign hdr_we = cmd.clear || (cmd.commit && hdr_cwe);
	assign hdr_wa = cmd.clear ? clr_cnt_q : hdr_cwa;
	assign hdr_wd = cmd.clear ? '0 : hdr_cwd;

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_wa] <= hdr_wd;
		end
	end

	// Link memory: the old list top is stored behind a freed block.
	always_ff @(posedge clk) begin
		if (cmd.commit && link_we) begin
			link_mem[addr_q] <= head_q[hdr_cls];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_block_q  <= res_block;
			out_usable_q <= res_usable;
			out_status_q <= res_status;
		end
	end

	assign block_address = out_block_q;
	assign usable_size   = out_usable_q;
	assign status        = out_status_q;

endmodule

FILE: rtl/core/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// Size-class block allocator
// Segregated free-list heap over 65536 granules of 16 bytes with 16 classes.
// Input channel (in_valid/in_stall) carries op, size and address; the output
// channel (out_valid/out_stall) returns block_address, usable_size, status.
// Each item is accepted in the idle state, looked up in the next cycle (class
// mapping, list head and registered header/link memory reads) and executed in
// the execute state after that; a new item is taken only once the last one has
// committed its result and the controller is back in the idle state.
// The result sits in an output register; a stalled receiver holds it there
// and a following item is taken and looked up, waiting in its execute step
// until the register frees.
// After reset the header memory is cleared, one entry a cycle, with in_stall
// high. The heap_limit register (cfg_wr_en/cfg_wr_data) resets to 65536; the
// user must write it only while no item is in flight: the block does not check.
// ----------------------------------------------------------------------------
module size_class_block_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [scba_pkg::LIMIT_W-1:0]     cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [scba_pkg::OP_W-1:0]        op,
	input  logic [scba_pkg::SIZE_W-1:0]      size,
	input  logic [scba_pkg::ADDR_W-1:0]      address,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [scba_pkg::ADDR_W-1:0]      block_address,
	output logic [scba_pkg::USABLE_W-1:0]    usable_size,
	output logic [scba_pkg::STATUS_W-1:0]    status
);
	import scba_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// Controller: sequencing and output valid.
	scba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: allocator state, memories and result register.
	scba_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.op            (op),
		.size          (size),
		.address       (address),
		.block_address (block_address),
		.usable_size   (usable_size),
		.status        (status)
	);

endmodule
